@@ rtl/tcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor/scroll engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int RROW_W  = 5;
    localparam int RCOL_W  = 7;
    localparam int OCOL_W  = 7;
    localparam int OLINE_W = 5;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic base;
        logic sweep_all;
        logic sweep_row;
        logic write_ch;
        logic read;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_op;
        logic scroll;
        logic write;
        logic read;
        logic last_all;
        logic last_row;
    } t_dp_sts;

endpackage

@@ rtl/tcc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_datapath
// Cell store, cursor, top-row pointer, address generation and result regs.
// ----------------------------------------------------------------------------
module tcc_datapath import tcc_pkg::*; #(
    parameter int ROWS = 32,
    parameter int COLS = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [RROW_W-1:0]  i_read_row,
    input  logic [RCOL_W-1:0]  i_read_col,
    output logic [CHAR_W-1:0]  o_cell_char,
    output logic [OCOL_W-1:0]  o_cur_column,
    output logic [OLINE_W-1:0] o_cur_line,
    output logic               o_did_scroll
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS + 1);

    logic [CHAR_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [RROW_W-1:0] r_rr;
    logic [RCOL_W-1:0] r_rc;

    logic [CW-1:0] r_col, n_col;
    logic [LW-1:0] r_line, n_line;
    logic [LW-1:0] r_top, n_top;
    logic          r_scroll, n_scroll;
    logic          r_write, n_write;
    logic          r_read, n_read;
    logic          r_clear, n_clear;
    logic [LW-1:0] r_row, n_row;
    logic [CW-1:0] r_off, n_off;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_k;
    logic [CHAR_W-1:0] r_rd;

    logic [LW+RROW_W-1:0] rr_ext;
    logic [CW+RCOL_W-1:0] rc_ext;
    logic [CW-1:0]        col_w;
    logic                 line_inc;
    logic                 wrap_scroll;
    logic [LW-1:0]        line_adv;
    logic [LW-1:0]        vis;
    logic [LW:0]          row_sum;
    logic                 rd_in_range;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic                 we;
    logic [CHAR_W-1:0]    wdata;
    logic [CW+OCOL_W-1:0] col_ext;
    logic [LW+OLINE_W-1:0] line_ext;

    always_comb begin
        rr_ext      = {{LW{1'b0}}, r_rr};
        rc_ext      = {{CW{1'b0}}, r_rc};
        rd_in_range = (rr_ext < (LW+RROW_W)'(ROWS)) && (rc_ext < (CW+RCOL_W)'(COLS));

        n_col    = r_col;
        n_line   = r_line;
        n_top    = r_top;
        n_scroll = 1'b0;
        n_write  = 1'b0;
        n_read   = 1'b0;
        n_clear  = 1'b0;
        line_inc = 1'b0;
        col_w    = r_col;

        case (r_op)
            OP_PUT: begin
                if (r_ch == CH_NEWLINE) begin
                    n_col    = '0;
                    line_inc = 1'b1;
                end else if (r_ch == CH_BACKSPACE) begin
                    if (r_col != '0) begin
                        n_col = r_col - CW'(1);
                    end
                end else if (r_ch != CH_RETURN) begin
                    if (r_col >= CW'(COLS)) begin
                        col_w    = '0;
                        line_inc = 1'b1;
                    end
                    n_col   = col_w + CW'(1);
                    n_write = 1'b1;
                end
            end
            OP_READ: begin
                n_read = rd_in_range;
            end
            OP_CLEAR: begin
                n_col   = '0;
                n_line  = '0;
                n_top   = '0;
                n_clear = 1'b1;
            end
            default: begin
            end
        endcase

        wrap_scroll = line_inc && (r_line == LW'(ROWS - 1));
        line_adv    = r_line + LW'(1);
        if (line_inc && !wrap_scroll) begin
            n_line = line_adv;
        end
        if (wrap_scroll) begin
            n_scroll = 1'b1;
            n_top    = (r_top == LW'(ROWS - 1)) ? '0 : r_top + LW'(1);
        end

        vis     = (r_op == OP_READ) ? rr_ext[LW-1:0] : n_line;
        row_sum = {1'b0, r_top} + {1'b0, vis};
        if (wrap_scroll) begin
            n_row = r_top;
        end else if (row_sum >= (LW+1)'(ROWS)) begin
            n_row = LW'(row_sum - (LW+1)'(ROWS));
        end else begin
            n_row = row_sum[LW-1:0];
        end
        n_off = (r_op == OP_READ) ? rc_ext[CW-1:0] : col_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_line   <= '0;
            r_top    <= '0;
            r_scroll <= 1'b0;
            r_write  <= 1'b0;
            r_read   <= 1'b0;
            r_clear  <= 1'b0;
            r_k      <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_col    <= n_col;
                r_line   <= n_line;
                r_top    <= n_top;
                r_scroll <= n_scroll;
                r_write  <= n_write;
                r_read   <= n_read;
                r_clear  <= n_clear;
            end
            if ((i_cmd.sweep_all && o_sts.last_all) || (i_cmd.sweep_row && o_sts.last_row)) begin
                r_k <= '0;
            end else if (i_cmd.sweep_all || i_cmd.sweep_row) begin
                r_k <= r_k + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_operation;
            r_ch <= i_char_code;
            r_rr <= i_read_row;
            r_rc <= i_read_col;
        end
        if (i_cmd.exec) begin
            r_row <= n_row;
            r_off <= n_off;
        end
        if (i_cmd.base) begin
            r_base <= AW'(r_row) * AW'(COLS);
        end
    end

    // store: one write port, one registered read port
    always_comb begin
        we    = i_cmd.sweep_all || i_cmd.sweep_row || i_cmd.write_ch;
        wdata = i_cmd.write_ch ? r_ch : '0;
        if (i_cmd.sweep_all) begin
            waddr = r_k;
        end else if (i_cmd.sweep_row) begin
            waddr = r_base + r_k;
        end else begin
            waddr = r_base + AW'(r_off);
        end
        raddr = r_base + AW'(r_off);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.read) begin
            r_rd <= mem[raddr];
        end
    end

    always_comb begin
        col_ext  = {{OCOL_W{1'b0}}, r_col};
        line_ext = {{OLINE_W{1'b0}}, r_line};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_cell_char  <= r_read ? r_rd : '0;
            o_cur_column <= col_ext[OCOL_W-1:0];
            o_cur_line   <= line_ext[OLINE_W-1:0];
            o_did_scroll <= r_scroll;
        end
    end

    always_comb begin
        o_sts.clear_op = r_clear;
        o_sts.scroll   = r_scroll;
        o_sts.write    = r_write;
        o_sts.read     = r_read;
        o_sts.last_all = (r_k == AW'(DEPTH - 1));
        o_sts.last_row = (r_k == AW'(COLS - 1));
    end

endmodule

@@ rtl/tcc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: store sweeps, per-transaction steps and output register valid.
// ----------------------------------------------------------------------------
module tcc_ctrl import tcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_BASE,
        S_ROWCLR,
        S_WRITE,
        S_READ,
        S_CLR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_all = 1'b1;
                if (i_sts.last_all) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                if (i_sts.clear_op) begin
                    n_state = S_CLR;
                end else if (i_sts.scroll) begin
                    n_state = S_ROWCLR;
                end else if (i_sts.write) begin
                    n_state = S_WRITE;
                end else if (i_sts.read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ROWCLR: begin
                o_cmd.sweep_row = 1'b1;
                if (i_sts.last_row) begin
                    n_state = i_sts.write ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                o_cmd.write_ch = 1'b1;
                n_state        = S_DONE;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_DONE;
            end
            S_CLR: begin
                o_cmd.sweep_all = 1'b1;
                if (i_sts.last_all) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/text_console_cursor_scroll.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell console: cell store with cursor, deferred wrap and scroll.
// ----------------------------------------------------------------------------
// Channel   Valid        Stall        Payload
// input     i_in_valid   o_in_stall   i_operation i_char_code i_read_row i_read_col
// output    o_out_valid  i_out_stall  o_cell_char o_cur_column o_cur_line o_did_scroll
//
// Printable put or on-screen read steps: accept, decode, row base multiply,
// one store access, result load. Newline, backspace, return, off-screen read
// and the unused code skip the store access. A scroll adds a sweep of COLS
// cells to blank the new bottom row; a clear adds a sweep of all ROWS*COLS
// cells of the store.
// After reset the store is swept with o_in_stall high.
// The result register holds while i_out_stall is high; the next transaction is
// taken and worked on meanwhile, and waits only at its own result load.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll import tcc_pkg::*; #(
    parameter int ROWS = 32,
    parameter int COLS = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [RROW_W-1:0]  i_read_row,
    input  logic [RCOL_W-1:0]  i_read_col,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CHAR_W-1:0]  o_cell_char,
    output logic [OCOL_W-1:0]  o_cur_column,
    output logic [OLINE_W-1:0] o_cur_line,
    output logic               o_did_scroll
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tcc_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_operation  (i_operation),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_cell_char  (o_cell_char),
        .o_cur_column (o_cur_column),
        .o_cur_line   (o_cur_line),
        .o_did_scroll (o_did_scroll)
    );

    // at most one store write source per cycle
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.sweep_all, w_cmd.sweep_row, w_cmd.write_ch}))
        else $error("multiple store write sources");

    // a result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten");

    // a scrolled transaction leaves the cursor on the last line
    a_scroll_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_did_scroll) |-> (o_cur_line == OLINE_W'(ROWS - 1)))
        else $error("scroll without cursor on last line");

    // no new transaction is taken while a store sweep runs
    a_sweep_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.sweep_all || w_cmd.sweep_row) |-> o_in_stall)
        else $error("input taken during store sweep");

endmodule

@@ tb/text_console_cursor_scroll_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Self-checking bench for the console engine: a directed table covers the
// edge cases (backspace at column 0, ignored return, byte zero, deferred wrap,
// scroll, reads off screen, unused opcode, clear), then random text lines,
// newline bursts, reads and noise run against a shadow screen with random
// idling on both channels.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;
    import tcc_pkg::*;

    localparam int ROWS       = 32;
    localparam int COLS       = 80;
    localparam int N_RAND     = 880;
    localparam int QUIET_MAX  = 20000;
    localparam int DRAIN_WAIT = 3000;
    localparam int DIR_N      = 25;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
    } t_txn;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_val;
        logic [OCOL_W-1:0]  column;
        logic [OLINE_W-1:0] line;
        logic               scrolled;
    } t_res;

    typedef struct packed {
        t_txn       txn;
        logic [7:0] reps;
        logic       typed;
        t_res       want;
    } t_dir_row;

    // typed rows carry their result; the rest go through the shadow screen
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{'{OP_READ,   8'h00,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
        '{'{OP_UNUSED, 8'hFF,        5'd31, 7'd127}, 8'd1,  1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
        '{'{OP_PUT,    8'h41,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd1, 5'd0, 1'b0}},
        '{'{OP_PUT,    8'h00,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd2, 5'd0, 1'b0}},
        '{'{OP_PUT,    8'hFF,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd3, 5'd0, 1'b0}},
        '{'{OP_PUT,    CH_BACKSPACE, 5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd2, 5'd0, 1'b0}},
        '{'{OP_PUT,    CH_RETURN,    5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd2, 5'd0, 1'b0}},
        '{'{OP_READ,   8'h00,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h41, 7'd2, 5'd0, 1'b0}},
        '{'{OP_READ,   8'h00,        5'd0,  7'd2},   8'd1,  1'b1, '{8'hFF, 7'd2, 5'd0, 1'b0}},
        '{'{OP_READ,   8'h00,        5'd31, 7'd79},  8'd1,  1'b1, '{8'h00, 7'd2, 5'd0, 1'b0}},
        '{'{OP_READ,   8'h00,        5'd0,  7'd80},  8'd1,  1'b1, '{8'h00, 7'd2, 5'd0, 1'b0}},
        '{'{OP_READ,   8'h00,        5'd0,  7'd127}, 8'd1,  1'b1, '{8'h00, 7'd2, 5'd0, 1'b0}},
        '{'{OP_PUT,    CH_NEWLINE,   5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd0, 5'd1, 1'b0}},
        '{'{OP_PUT,    CH_BACKSPACE, 5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd0, 5'd1, 1'b0}},
        '{'{OP_CLEAR,  8'h00,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
        '{'{OP_READ,   8'h00,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
        '{'{OP_PUT,    8'h61,        5'd0,  7'd0},   8'd80, 1'b0, '0},
        '{'{OP_READ,   8'h00,        5'd0,  7'd79},  8'd1,  1'b0, '0},
        '{'{OP_PUT,    CH_BACKSPACE, 5'd0,  7'd0},   8'd1,  1'b0, '0},
        '{'{OP_PUT,    8'h62,        5'd0,  7'd0},   8'd2,  1'b0, '0},
        '{'{OP_PUT,    CH_NEWLINE,   5'd0,  7'd0},   8'd31, 1'b0, '0},
        '{'{OP_PUT,    8'h63,        5'd0,  7'd0},   8'd81, 1'b0, '0},
        '{'{OP_READ,   8'h00,        5'd31, 7'd0},   8'd1,  1'b0, '0},
        '{'{OP_READ,   8'h00,        5'd30, 7'd79},  8'd1,  1'b0, '0},
        '{'{OP_CLEAR,  8'h00,        5'd0,  7'd0},   8'd1,  1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [OP_W-1:0]    i_operation = OP_PUT;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic [RROW_W-1:0]  i_read_row  = '0;
    logic [RCOL_W-1:0]  i_read_col  = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [CHAR_W-1:0]  o_cell_char;
    logic [OCOL_W-1:0]  o_cur_column;
    logic [OLINE_W-1:0] o_cur_line;
    logic               o_did_scroll;

    text_console_cursor_scroll #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cell_char (o_cell_char),
        .o_cur_column(o_cur_column),
        .o_cur_line  (o_cur_line),
        .o_did_scroll(o_did_scroll)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow screen
    logic [CHAR_W-1:0] shadow_cells [ROWS*COLS];
    int unsigned       top_row;
    int unsigned       cur_col;
    int unsigned       cur_line;

    t_res pending_results [$];
    bit   idle_on;
    int   n_err;
    int   n_results;
    int   n_put, n_read, n_clear, n_scroll, n_wrap;
    int   quiet;
    int   stall_left;

    task automatic report_error(input string msg);
        n_err++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic bit advance_line();
        cur_line++;
        if (cur_line >= ROWS) begin
            for (int c = 0; c < COLS; c++) shadow_cells[top_row*COLS + c] = '0;
            top_row  = (top_row + 1) % ROWS;
            cur_line = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_res console_step(input t_txn t);
        t_res r;
        bit   scr;
        r   = '0;
        scr = 1'b0;
        case (t.op)
            OP_PUT: begin
                if (t.ch == CH_NEWLINE) begin
                    cur_col = 0;
                    scr = advance_line();
                end else if (t.ch == CH_BACKSPACE) begin
                    if (cur_col > 0) cur_col--;
                end else if (t.ch != CH_RETURN) begin
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        scr = advance_line();
                        n_wrap++;
                    end
                    shadow_cells[((top_row + cur_line) % ROWS)*COLS + cur_col] = t.ch;
                    cur_col++;
                end
            end
            OP_READ: begin
                if (t.row < ROWS && t.col < COLS)
                    r.char_val = shadow_cells[((top_row + t.row) % ROWS)*COLS + t.col];
            end
            OP_CLEAR: begin
                foreach (shadow_cells[i]) shadow_cells[i] = '0;
                top_row  = 0;
                cur_col  = 0;
                cur_line = 0;
            end
            default: ;
        endcase
        r.column   = cur_col[OCOL_W-1:0];
        r.line     = cur_line[OLINE_W-1:0];
        r.scrolled = scr;
        n_scroll  += scr;
        return r;
    endfunction

    task automatic send_txn(input t_txn t, input bit typed, input t_res want);
        t_res pred;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= t.op;
        i_char_code <= t.ch;
        i_read_row  <= t.row;
        i_read_col  <= t.col;
        do @(posedge i_clk); while (o_in_stall);
        pred = console_step(t);
        pending_results.push_back(typed ? want : pred);
        case (t.op)
            OP_PUT:   n_put++;
            OP_READ:  n_read++;
            OP_CLEAR: n_clear++;
            default: ;
        endcase
    endtask

    // output side: random stall bursts, checking, watchdog
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 4);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing pending", n_results));
            end else begin
                want = pending_results.pop_front();
                if (o_cell_char !== want.char_val)
                    report_error($sformatf("result %0d cell_char %0d, expected %0d",
                                           n_results, o_cell_char, want.char_val));
                if (o_cur_column !== want.column)
                    report_error($sformatf("result %0d cur_column %0d, expected %0d",
                                           n_results, o_cur_column, want.column));
                if (o_cur_line !== want.line)
                    report_error($sformatf("result %0d cur_line %0d, expected %0d",
                                           n_results, o_cur_line, want.line));
                if (o_did_scroll !== want.scrolled)
                    report_error($sformatf("result %0d did_scroll %0d, expected %0d",
                                           n_results, o_did_scroll, want.scrolled));
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("Timeout: no transaction for %0d cycles", QUIET_MAX);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_txn t;
        int   n_rand;
        int   pick;
        int   len;
        bit   drained;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        top_row    = 0;
        cur_col    = 0;
        cur_line   = 0;
        idle_on    = 1'b1;
        stall_left = 0;
        n_rand     = 0;
        drained    = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            for (int k = 0; k < DIR_TAB[i].reps; k++)
                send_txn(DIR_TAB[i].txn, DIR_TAB[i].typed, DIR_TAB[i].want);

        while (n_rand < N_RAND) begin
            if (n_rand > N_RAND - 150)
                idle_on = 1'b0;
            else if ($urandom_range(0, 7) == 0)
                idle_on = !idle_on;

            if (!drained && n_rand >= N_RAND/2) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end

            pick = $urandom_range(0, 99);
            t    = '0;
            if (pick < 40) begin
                // a line of text, sometimes longer than the screen width
                len  = $urandom_range(1, 90);
                t.op = OP_PUT;
                for (int k = 0; k < len; k++) begin
                    t.ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(32, 126));
                    send_txn(t, 1'b0, '0);
                    n_rand++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    t.ch = CH_NEWLINE;
                    send_txn(t, 1'b0, '0);
                    n_rand++;
                end
            end else if (pick < 55) begin
                t.op = OP_PUT;
                t.ch = CH_NEWLINE;
                len  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_txn(t, 1'b0, '0);
                    n_rand++;
                end
            end else if (pick < 80) begin
                len  = $urandom_range(2, 10);
                t.op = OP_READ;
                for (int k = 0; k < len; k++) begin
                    t.ch  = 8'($urandom_range(0, 255));
                    t.row = ($urandom_range(0, 1) == 1) ? 5'(cur_line)
                                                       : 5'($urandom_range(0, ROWS-1));
                    t.col = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(0, COLS-1));
                    send_txn(t, 1'b0, '0);
                    n_rand++;
                end
            end else if (pick < 88) begin
                len  = $urandom_range(1, 6);
                t.op = OP_PUT;
                for (int k = 0; k < len; k++) begin
                    t.ch = ($urandom_range(0, 3) == 0) ? CH_RETURN : CH_BACKSPACE;
                    send_txn(t, 1'b0, '0);
                    n_rand++;
                end
            end else if (pick < 93) begin
                t.op  = OP_UNUSED;
                t.ch  = 8'($urandom_range(0, 255));
                t.row = 5'($urandom_range(0, 31));
                t.col = 7'($urandom_range(0, 127));
                send_txn(t, 1'b0, '0);
                n_rand++;
            end else if (pick < 99) begin
                t.op  = OP_PUT;
                t.ch  = 8'($urandom_range(0, 255));
                t.row = 5'($urandom_range(0, 31));
                t.col = 7'($urandom_range(0, 127));
                send_txn(t, 1'b0, '0);
                n_rand++;
            end else begin
                t.op = OP_CLEAR;
                send_txn(t, 1'b0, '0);
                n_rand++;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d puts, %0d reads, %0d clears; %0d results checked",
                 n_put, n_read, n_clear, n_results);
        $display("Cursor hit %0d deferred wraps and %0d scrolls", n_wrap, n_scroll);
        if (n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
